[rtl/core/stable_sorted_event_queue_defines.svh]
// ----------------------------------------------------------------------------
// Stable sorted event queue: assertion macros
// Concurrent checks sampled on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_EVENT_QUEUE_DEFINES_SVH
`define STABLE_SORTED_EVENT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cond holds whenever trig holds, in the same cycle.
`define SSEQ_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("sseq check failed");

// Check that cond holds in the cycle after trig.
`define SSEQ_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("sseq check failed");

`else

`define SSEQ_ASSERT_SAME(lbl, trig, cond)
`define SSEQ_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

[rtl/core/sseq_pkg.sv]
// ----------------------------------------------------------------------------
// sseq_pkg
// Shared constants, codes and beat types of the stable sorted event queue.
// ----------------------------------------------------------------------------
package sseq_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);

  localparam int OP_W    = 3;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 16;
  localparam int MAXC_W  = 5;
  localparam int COUNT_W = 5;
  localparam int DUMP_W  = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [TIME_W-1:0] event_time;
    logic signed [KIND_W-1:0] event_kind;
    logic [MAXC_W-1:0]        max_count;
  } in_item_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] out_time;
    logic signed [KIND_W-1:0] out_kind;
    logic                     valid_res;
    logic                     last;
    logic [COUNT_W-1:0]       count;
    logic                     overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_POP,
    CMD_PEEK,
    CMD_CLEAR,
    CMD_DUMP,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [TIME_W-1:0] event_time;
    logic signed [KIND_W-1:0] event_kind;
    logic [MAXC_W-1:0]        max_count;
  } cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic {
    BK_RUN,
    BK_DUMP
  } back_state_t;

endpackage

[rtl/core/sseq_front.sv]
// ----------------------------------------------------------------------------
// sseq_front
// Decodes accepted operations and holds them in a two-slot command queue.
// ----------------------------------------------------------------------------
module sseq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sseq_pkg::in_item_t in_item,
  input  logic               pop,
  output sseq_pkg::q_head_t  head
);
  import sseq_pkg::*;

  cmd_t              dec_cmd;
  logic              push;
  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    dec_cmd.event_time = in_item.event_time;
    dec_cmd.event_kind = in_item.event_kind;
    dec_cmd.max_count  = in_item.max_count;
    unique case (in_item.op)
      OP_INSERT: dec_cmd.kind = CMD_INSERT;
      OP_POP:    dec_cmd.kind = CMD_POP;
      OP_PEEK:   dec_cmd.kind = CMD_PEEK;
      OP_CLEAR:  dec_cmd.kind = CMD_CLEAR;
      OP_DUMP:   dec_cmd.kind = CMD_DUMP;
      default:   dec_cmd.kind = CMD_NOP;
    endcase
  end

  assign busy = (fill_r == QCNT_W'(QDEPTH));
  assign push = start && !busy;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec_cmd;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];

endmodule

[rtl/core/sseq_back.sv]
// ----------------------------------------------------------------------------
// sseq_back
// Sorted shift-register cells and the sequencer that runs queued commands.
// ----------------------------------------------------------------------------
module sseq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sseq_pkg::q_head_t   head,
  output logic                pop,
  output logic                out_strobe,
  output sseq_pkg::out_item_t out_res
);
  import sseq_pkg::*;

  logic signed [TIME_W-1:0] cell_time_r   [DEPTH];
  logic signed [KIND_W-1:0] cell_kind_r   [DEPTH];
  logic signed [TIME_W-1:0] cell_time_nxt [DEPTH];
  logic signed [KIND_W-1:0] cell_kind_nxt [DEPTH];
  logic signed [TIME_W-1:0] ins_time      [DEPTH];
  logic signed [KIND_W-1:0] ins_kind      [DEPTH];
  logic signed [TIME_W-1:0] shl_time      [DEPTH];
  logic signed [KIND_W-1:0] shl_kind      [DEPTH];
  logic [DEPTH-1:0]         le;

  logic [CNT_W-1:0]  count_r, count_nxt;
  back_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  dump_idx_r, dump_idx_nxt;
  logic [IDX_W-1:0]  dump_last_r, dump_last_nxt;
  logic [DUMP_W-1:0] dump_n;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_res_r, out_res_nxt;

  // Per-cell insert and pop views; each insert cell decides from its own compare and that of the cell before it.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count_r) &&
              !($signed(cell_time_r[i]) > $signed(head.cmd.event_time));
    end
    ins_time[0] = le[0] ? cell_time_r[0] : head.cmd.event_time;
    ins_kind[0] = le[0] ? cell_kind_r[0] : head.cmd.event_kind;
    for (int i = 1; i < DEPTH; i++) begin
      if (le[i]) begin
        ins_time[i] = cell_time_r[i];
        ins_kind[i] = cell_kind_r[i];
      end else if (le[i-1]) begin
        ins_time[i] = head.cmd.event_time;
        ins_kind[i] = head.cmd.event_kind;
      end else begin
        ins_time[i] = cell_time_r[i-1];
        ins_kind[i] = cell_kind_r[i-1];
      end
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      shl_time[i] = cell_time_r[i+1];
      shl_kind[i] = cell_kind_r[i+1];
    end
    shl_time[DEPTH-1] = cell_time_r[DEPTH-1];
    shl_kind[DEPTH-1] = cell_kind_r[DEPTH-1];
  end

  // Dump length: min(max_count, count, MAX_RESULTS).
  always_comb begin
    logic [DUMP_W-1:0] mc;
    logic [DUMP_W-1:0] cn;
    mc = DUMP_W'(head.cmd.max_count);
    cn = DUMP_W'(count_r);
    dump_n = (mc < cn) ? mc : cn;
    if (dump_n > DUMP_W'(MAX_RESULTS)) begin
      dump_n = DUMP_W'(MAX_RESULTS);
    end
  end

  always_comb begin
    cell_time_nxt  = cell_time_r;
    cell_kind_nxt  = cell_kind_r;
    count_nxt      = count_r;
    state_nxt      = state_r;
    dump_idx_nxt   = dump_idx_r;
    dump_last_nxt  = dump_last_r;
    pop            = 1'b0;
    out_strobe_nxt = 1'b0;
    out_res_nxt.out_time  = '1;
    out_res_nxt.out_kind  = '1;
    out_res_nxt.valid_res = 1'b0;
    out_res_nxt.last      = 1'b1;
    out_res_nxt.overflow  = 1'b0;
    out_res_nxt.count     = '0;

    unique case (state_r)
      BK_RUN: begin
        if (head.valid) begin
          pop            = 1'b1;
          out_strobe_nxt = 1'b1;
          unique case (head.cmd.kind)
            CMD_INSERT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_res_nxt.overflow = 1'b1;
              end else begin
                cell_time_nxt = ins_time;
                cell_kind_nxt = ins_kind;
                count_nxt     = count_r + 1'b1;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (count_r != '0) begin
                out_res_nxt.out_time  = cell_time_r[0];
                out_res_nxt.out_kind  = cell_kind_r[0];
                out_res_nxt.valid_res = 1'b1;
                if (head.cmd.kind == CMD_POP) begin
                  cell_time_nxt = shl_time;
                  cell_kind_nxt = shl_kind;
                  count_nxt     = count_r - 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_DUMP: begin
              if (dump_n != '0) begin
                out_res_nxt.out_time  = cell_time_r[0];
                out_res_nxt.out_kind  = cell_kind_r[0];
                out_res_nxt.valid_res = 1'b1;
                if (dump_n != DUMP_W'(1)) begin
                  out_res_nxt.last = 1'b0;
                  state_nxt        = BK_DUMP;
                  dump_idx_nxt     = IDX_W'(1);
                  dump_last_nxt    = IDX_W'(dump_n - 1'b1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_DUMP: begin
        out_strobe_nxt        = 1'b1;
        out_res_nxt.out_time  = cell_time_r[dump_idx_r];
        out_res_nxt.out_kind  = cell_kind_r[dump_idx_r];
        out_res_nxt.valid_res = 1'b1;
        out_res_nxt.last      = (dump_idx_r == dump_last_r);
        if (dump_idx_r == dump_last_r) begin
          state_nxt = BK_RUN;
        end else begin
          dump_idx_nxt = dump_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase

    out_res_nxt.count = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_RUN;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
      dump_idx_r   <= '0;
      dump_last_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      dump_idx_r   <= dump_idx_nxt;
      dump_last_r  <= dump_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_time_r <= cell_time_nxt;
    cell_kind_r <= cell_kind_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

[rtl/core/stable_sorted_event_queue.sv]
// ----------------------------------------------------------------------------
// stable_sorted_event_queue
// Path: an accepted op is written into a command slot; the back end takes
// it from the queue and registers its result beat onto the out_ ports.
// Beats: insert, pop, peek, clear and unknown ops give a single beat each;
// a dump of n entries gives one beat per dumped entry (at least one beat),
// and no new op leaves the queue while it runs. A two-slot command queue
// lets up to two ops wait; busy is high while both slots are full.
// Reset: synchronous, rst_n low empties the queue and the command slots.
// ----------------------------------------------------------------------------
module stable_sorted_event_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sseq_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output sseq_pkg::out_item_t out_res
);
  import sseq_pkg::*;

`include "stable_sorted_event_queue_defines.svh"

  // Front end: decode the op and park it in the command queue.
  q_head_t head;
  logic    pop;

  sseq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .pop     (pop),
    .head    (head)
  );

  // Back end: run one command at a time against the sorted cells.
  // Inserts compare all cells at once and shift the tail right by one;
  // pops shift everything left; a dump walks the cells front to back.
  // Every result beat is registered, so the receiver sees the first beat
  // of a command in the cycle after the command leaves the queue.
  sseq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  // A dropped insert never carries an entry.
  `SSEQ_ASSERT_SAME(a_ovf_no_entry, out_strobe && out_res.overflow, !out_res.valid_res)
  // A beat without an entry reports the none marker in both fields.
  `SSEQ_ASSERT_SAME(a_none_marker, out_strobe && !out_res.valid_res, (&out_res.out_time) && (&out_res.out_kind))
  // A dump run is contiguous: a beat that is not last is followed at once.
  `SSEQ_ASSERT_NEXT(a_run_contig, out_strobe && !out_res.last, out_strobe)

endmodule
